FILE: src/lookahead_peak_limiter_assert.svh
// assertion macros for the look-ahead peak limiter
// needs a clock named i_clk and an active-low reset named i_rst_n in the using module
`ifndef LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_ASSERT_SVH
`ifndef SYNTH
`define LPL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lookahead_peak_limiter: same-cycle check failed");
`define LPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lookahead_peak_limiter: next-cycle check failed");
`else
`define LPL_ASSERT_IMPL(label, ante, cons)
`define LPL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/lpl_pkg.sv
// types, constants and constant tables of the look-ahead peak limiter
// no dependencies
package lpl_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SPAN       = 2 * RING_DEPTH;
    localparam int CNT_W      = $clog2(SPAN);

    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = 24;
    localparam int KNEE_W     = 13;
    localparam int COEF_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int LOG_W      = 21;
    localparam int DIV_W      = 48;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd8388608;
    localparam logic [18:0]       DB_PER_OCT = 19'd394566;
    localparam logic [13:0]       OCT_PER_DB = 14'd10885;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING  = 3'd0,
        CFG_KNEE     = 3'd1,
        CFG_ACT      = 3'd2,
        CFG_REL_IDLE = 3'd3,
        CFG_REL_LIM  = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_BACK_RD,
        S_BACK_MAG,
        S_BACK_CMP,
        S_PUSH,
        S_EMIT,
        S_PEAK_RD,
        S_PEAK,
        S_NORM,
        S_SQ,
        S_REL,
        S_KNEE,
        S_DIV,
        S_DIV_END,
        S_ATT,
        S_EXP,
        S_EXP_END,
        S_GAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [MAG_W-1:0]           peak_magnitude;
        logic                       frame_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_last_out;
    } t_out_beat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [MAG_W-1:0]    mag;
    } t_ring_entry;

    function automatic logic [RING_AW-1:0] slot_inc(input logic [RING_AW-1:0] s);
        return (s == RING_AW'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_W'(SPAN - 1)) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? CNT_W'(SPAN - 1) : c - 1'b1;
    endfunction

    function automatic logic [RING_AW-1:0] cnt_idx(input logic [CNT_W-1:0] c);
        return (c >= CNT_W'(RING_DEPTH)) ? RING_AW'(c - CNT_W'(RING_DEPTH)) : RING_AW'(c);
    endfunction

    // elaboration only: integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 2^-(2^-(k+1)) in Q0.32
    function automatic logic [31:0] exp_tbl_entry(input int k);
        logic [63:0] t;
        t = isqrt64(64'd1 << 63);
        for (int j = 1; j <= k; j++) begin
            t = isqrt64(t << 32);
        end
        return t[31:0];
    endfunction

    localparam logic [31:0] EXP_TBL [16] = '{
        exp_tbl_entry(0),  exp_tbl_entry(1),  exp_tbl_entry(2),  exp_tbl_entry(3),
        exp_tbl_entry(4),  exp_tbl_entry(5),  exp_tbl_entry(6),  exp_tbl_entry(7),
        exp_tbl_entry(8),  exp_tbl_entry(9),  exp_tbl_entry(10), exp_tbl_entry(11),
        exp_tbl_entry(12), exp_tbl_entry(13), exp_tbl_entry(14), exp_tbl_entry(15)
    };

endpackage

FILE: src/lookahead_peak_limiter.sv
// look-ahead peak limiter: ring and deque memories, sequencer, log/divide/exp units
// depends on lpl_pkg and lookahead_peak_limiter_assert.svh
//
//   port group | direction | handshake            | payload
//   in         | sink      | i_in_valid/o_in_stall | t_in_beat
//   out        | source    | o_out_valid/i_out_stall | t_out_beat
//   cfg        | sink      | i_cfg_we              | i_cfg_index, i_cfg_data
//
// one beat at a time: the input stalls from accept until the beat enters the output register
// the back scan drops deque entries from the back while they are not larger than the new one
// a ratio gain adds the bit-serial divider; a soft knee adds two log2 runs
// (normalisation shifts and 16 squarings each), rel and knee steps, the divider unless
// below the knee, and the exp steps only inside it
// ring contents read as zero until written through a fill flag, no clearing pass
// a finished beat waits in the output register while the next input beat is taken
`include "lookahead_peak_limiter_assert.svh"
module lookahead_peak_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  lpl_pkg::t_in_beat               i_in_beat,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output lpl_pkg::t_out_beat              o_out_beat,
    input  logic                            i_out_stall,
    input  logic                            i_cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lpl_pkg::*;

    // config
    logic [MAG_W-1:0]  r_ceiling;
    logic [KNEE_W-1:0] r_knee;
    logic [MAG_W-1:0]  r_act;
    logic [COEF_W-1:0] r_rel_idle;
    logic [COEF_W-1:0] r_rel_lim;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_tail;
    logic [RING_AW-1:0] r_wp;
    logic               r_wrapped;
    logic [GAIN_W-1:0]  r_gain;
    logic               r_out_valid;
    t_out_beat          r_out_beat;
    logic [5:0]         r_cnt;
    logic               r_log_sel;
    logic               r_div_knee;

    // payload
    logic [SAMPLE_W-1:0] r_raw;
    logic [MAG_W-1:0]    r_mag;
    logic                r_last;
    logic [SAMPLE_W-1:0] r_emit;
    logic [MAG_W-1:0]    r_peak;
    logic [30:0]         r_lm;
    logic [4:0]          r_ln;
    logic [LOG_W-1:0]    r_lres;
    logic [LOG_W-1:0]    r_logp;
    logic signed [25:0]  r_rel;
    logic [DIV_W-1:0]    r_dq;
    logic [MAG_W-1:0]    r_drem;
    logic [MAG_W-1:0]    r_dden;
    logic [20:0]         r_red;
    logic [18:0]         r_att;
    logic [32:0]         r_g;
    logic [GAIN_W-1:0]   r_req;

    // memories
    t_ring_entry        ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] dq_mem   [RING_DEPTH];
    t_ring_entry        r_ring_rdata;
    logic               r_ring_ok;
    logic [RING_AW-1:0] r_dq_rdata;

    logic               ring_we;
    logic [RING_AW-1:0] ring_raddr;
    logic               dq_we;
    logic [RING_AW-1:0] dq_raddr;

    logic               in_accept;
    logic               out_free;
    logic [MAG_W-1:0]   ring_mag;
    logic [CNT_W-1:0]   dq_len;

    // datapath
    logic [61:0]         sq_prod;
    logic [31:0]         sq_top;
    logic signed [21:0]  log_diff;
    logic [20:0]         log_mag;
    logic [39:0]         db_prod;
    logic [40:0]         db_sum;
    logic [24:0]         db_round;
    logic signed [26:0]  rel_x;
    logic signed [26:0]  half_x;
    logic [20:0]         knee_x;
    logic [41:0]         knee_sq;
    logic [25:0]         div_trial;
    logic                div_fit;
    logic [34:0]         att_prod;
    logic [35:0]         att_sum;
    logic [3:0]          exp_k;
    logic [64:0]         exp_prod;
    logic [32:0]         exp_sh;
    logic [33:0]         exp_rnd;
    logic [24:0]         exp_gain;
    logic [COEF_W-1:0]   rel_coef;
    logic [24:0]         one_m;
    logic [GAIN_W-1:0]   gain_delta;
    logic [48:0]         rel_prod;
    logic [49:0]         rel_sum;
    logic [25:0]         rel_inc;
    logic [25:0]         gain_sum;
    logic signed [48:0]  out_prod;
    logic signed [49:0]  out_sum;
    logic signed [26:0]  out_q;
    logic signed [SAMPLE_W-1:0] out_sat;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign ring_mag    = r_ring_ok ? r_ring_rdata.mag : '0;
    assign dq_len      = r_tail - r_head + CNT_W'(SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling  <= 24'd4194304;
            r_knee     <= '0;
            r_act      <= '0;
            r_rel_idle <= '0;
            r_rel_lim  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CEILING:  r_ceiling  <= i_cfg_data;
                CFG_KNEE:     r_knee     <= i_cfg_data[KNEE_W-1:0];
                CFG_ACT:      r_act      <= i_cfg_data;
                CFG_REL_IDLE: r_rel_idle <= i_cfg_data;
                CFG_REL_LIM:  r_rel_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_wp] <= '{sample: r_raw, mag: r_mag};
        end
        r_ring_rdata <= ring_mem[ring_raddr];
        r_ring_ok    <= r_wrapped || (ring_raddr < r_wp);
    end

    always_ff @(posedge i_clk) begin
        if (dq_we) begin
            dq_mem[cnt_idx(r_tail)] <= r_wp;
        end
        r_dq_rdata <= dq_mem[dq_raddr];
    end

    always_comb begin
        sq_prod    = r_lm * r_lm;
        sq_top     = sq_prod[61:30];
        log_diff   = $signed({1'b0, r_logp}) - $signed({1'b0, r_lres});
        log_mag    = log_diff[21] ? 21'(-log_diff) : log_diff[20:0];
        db_prod    = log_mag * DB_PER_OCT;
        db_sum     = {1'b0, db_prod} + 41'd32768;
        db_round   = db_sum[40:16];
        rel_x      = 27'(r_rel);
        half_x     = $signed({7'd0, r_knee, 7'd0});
        knee_x     = 21'(r_rel + $signed({6'd0, r_knee, 7'd0}));
        knee_sq    = knee_x * knee_x;
        div_trial  = {1'b0, r_drem, r_dq[DIV_W-1]} - {2'b0, r_dden};
        div_fit    = !div_trial[25];
        att_prod   = r_red * OCT_PER_DB;
        att_sum    = {1'b0, att_prod} + 36'd32768;
        exp_k      = r_cnt[3:0];
        exp_prod   = r_g * EXP_TBL[exp_k];
        exp_sh     = r_g >> r_att[18:16];
        exp_rnd    = ({1'b0, exp_sh} + 34'd256) >> 9;
        exp_gain   = (exp_rnd > 34'(UNITY_GAIN)) ? 25'(UNITY_GAIN) : exp_rnd[24:0];
        rel_coef   = (r_req < UNITY_GAIN) ? r_rel_lim : r_rel_idle;
        one_m      = 25'h1000000 - {1'b0, rel_coef};
        gain_delta = r_req - r_gain;
        rel_prod   = gain_delta * one_m;
        rel_sum    = {1'b0, rel_prod} + 50'h800000;
        rel_inc    = rel_sum[49:24];
        gain_sum   = {2'b0, r_gain} + rel_inc;
        out_prod   = $signed(r_emit) * $signed({1'b0, r_gain});
        out_sum    = 50'(out_prod) + 50'sd4194304;
        out_q      = 27'(out_sum >>> 23);
        if (out_q > 27'sd8388607) begin
            out_sat = 24'sh7FFFFF;
        end else if (out_q < -27'sd8388608) begin
            out_sat = 24'sh800000;
        end else begin
            out_sat = out_q[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        ring_we    = 1'b0;
        ring_raddr = '0;
        dq_we      = 1'b0;
        dq_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                dq_raddr = cnt_idx(r_head);
                n_state  = S_HEAD_CHK;
            end
            S_HEAD_CHK: n_state = S_BACK_RD;
            S_BACK_RD: begin
                if (r_head == r_tail) begin
                    n_state = S_PUSH;
                end else begin
                    dq_raddr = cnt_idx(cnt_dec(r_tail));
                    n_state  = S_BACK_MAG;
                end
            end
            S_BACK_MAG: begin
                ring_raddr = r_dq_rdata;
                n_state    = S_BACK_CMP;
            end
            S_BACK_CMP: n_state = (ring_mag > r_mag) ? S_PUSH : S_BACK_RD;
            S_PUSH: begin
                dq_we      = 1'b1;
                ring_raddr = slot_inc(r_wp);
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                ring_we  = 1'b1;
                dq_raddr = cnt_idx(r_head);
                n_state  = S_PEAK_RD;
            end
            S_PEAK_RD: begin
                ring_raddr = r_dq_rdata;
                n_state    = S_PEAK;
            end
            S_PEAK: begin
                if (ring_mag < r_act || ring_mag == '0 || r_ceiling == '0) begin
                    n_state = S_GAIN;
                end else if (r_knee == '0) begin
                    n_state = (ring_mag > r_ceiling) ? S_DIV : S_GAIN;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: n_state = r_lm[30] ? S_SQ : S_NORM;
            S_SQ: begin
                if (r_cnt == '0) begin
                    n_state = r_log_sel ? S_REL : S_NORM;
                end
            end
            S_REL: n_state = S_KNEE;
            S_KNEE: begin
                if (rel_x <= -half_x) begin
                    n_state = S_GAIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: n_state = r_div_knee ? S_ATT : S_GAIN;
            S_ATT:     n_state = S_EXP;
            S_EXP: begin
                if (exp_k == 4'd15) begin
                    n_state = S_EXP_END;
                end
            end
            S_EXP_END: n_state = S_GAIN;
            S_GAIN:    n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_gain      <= UNITY_GAIN;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_log_sel   <= 1'b0;
            r_div_knee  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_raw  <= i_in_beat.sample_in;
                        r_mag  <= i_in_beat.peak_magnitude;
                        r_last <= i_in_beat.frame_last;
                    end
                end
                S_HEAD_CHK: begin
                    if (r_head != r_tail && r_dq_rdata == r_wp) begin
                        r_head <= cnt_inc(r_head);
                    end
                end
                S_BACK_CMP: begin
                    if (!(ring_mag > r_mag)) begin
                        r_tail <= cnt_dec(r_tail);
                    end
                end
                S_PUSH: r_tail <= cnt_inc(r_tail);
                S_EMIT: begin
                    if (RING_DEPTH == 1) begin
                        r_emit <= r_raw;
                    end else begin
                        r_emit <= r_ring_ok ? r_ring_rdata.sample : '0;
                    end
                    r_wp <= slot_inc(r_wp);
                    if (r_wp == RING_AW'(RING_DEPTH - 1)) begin
                        r_wrapped <= 1'b1;
                    end
                end
                S_PEAK: begin
                    r_peak    <= ring_mag;
                    r_req     <= UNITY_GAIN;
                    r_lm      <= {7'd0, ring_mag};
                    r_ln      <= 5'd30;
                    r_log_sel <= 1'b0;
                    // hard knee over the ceiling goes straight to the divider
                    r_div_knee <= 1'b0;
                    r_dq       <= {1'b0, ring_mag == '0 ? '0 : r_ceiling, 23'd0};
                    r_drem     <= '0;
                    r_dden     <= ring_mag;
                    r_cnt      <= 6'(DIV_W - 1);
                end
                S_NORM: begin
                    if (r_lm[30]) begin
                        r_lres <= {r_ln, 16'd0};
                        r_cnt  <= 6'd15;
                    end else begin
                        r_lm <= {r_lm[29:0], 1'b0};
                        r_ln <= r_ln - 1'b1;
                    end
                end
                S_SQ: begin
                    if (sq_top[31]) begin
                        r_lres[r_cnt[3:0]] <= 1'b1;
                    end
                    if (r_cnt == '0 && !r_log_sel) begin
                        r_logp    <= r_lres | (LOG_W'(sq_top[31]) << r_cnt[3:0]);
                        r_log_sel <= 1'b1;
                        r_lm      <= {7'd0, r_ceiling};
                        r_ln      <= 5'd30;
                    end else if (sq_top[31]) begin
                        r_lm <= sq_top[31:1];
                    end else begin
                        r_lm <= sq_top[30:0];
                    end
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_REL: r_rel <= log_diff[21] ? -$signed({1'b0, db_round}) : $signed({1'b0, db_round});
                S_KNEE: begin
                    r_drem <= '0;
                    r_cnt  <= 6'(DIV_W - 1);
                    if (rel_x >= half_x) begin
                        r_div_knee <= 1'b0;
                        r_dq       <= {1'b0, r_peak == '0 ? '0 : r_ceiling, 23'd0};
                        r_dden     <= r_peak;
                    end else begin
                        r_div_knee <= 1'b1;
                        r_dq       <= DIV_W'(knee_sq) + DIV_W'({r_knee, 8'd0});
                        r_dden     <= MAG_W'({r_knee, 9'd0});
                    end
                end
                S_DIV: begin
                    r_dq <= {r_dq[DIV_W-2:0], div_fit};
                    r_drem <= div_fit ? div_trial[23:0] : {r_drem[22:0], r_dq[DIV_W-1]};
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV_END: begin
                    r_red <= r_dq[20:0];
                    r_req <= (r_dq > DIV_W'(UNITY_GAIN)) ? UNITY_GAIN : r_dq[GAIN_W-1:0];
                end
                S_ATT: begin
                    r_att <= att_sum[34:16];
                    r_g   <= 33'h1_0000_0000;
                    r_cnt <= '0;
                end
                S_EXP: begin
                    if (r_att[4'd15 - exp_k]) begin
                        r_g <= exp_prod[64:32];
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_EXP_END: r_req <= exp_gain[GAIN_W-1:0];
                S_GAIN: begin
                    if (r_req <= r_gain) begin
                        r_gain <= r_req;
                    end else if (gain_sum > 26'(r_req)) begin
                        r_gain <= r_req;
                    end else begin
                        r_gain <= gain_sum[GAIN_W-1:0];
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_beat  <= '{sample_out: out_sat, frame_last_out: r_last};
                    end
                end
                default: ;
            endcase
        end
    end

    `LPL_ASSERT_IMPL(a_gain_unity, 1'b1, r_gain <= UNITY_GAIN)
    `LPL_ASSERT_IMPL(a_dq_len, 1'b1, dq_len <= CNT_W'(RING_DEPTH))
    `LPL_ASSERT_NEXT(a_accept_busy, in_accept, o_in_stall)
    `LPL_ASSERT_IMPL(a_peak_nonempty, r_state == S_PEAK, r_head != r_tail)
    `LPL_ASSERT_NEXT(a_out_load, r_state == S_OUT && out_free, o_out_valid && !o_in_stall)

endmodule

FILE: tb/tb_lookahead_peak_limiter.sv
// self-checking testbench for the look-ahead peak limiter: bursty sender, stalling receiver,
// in-bench gain predictor checked beat by beat against the block's output
// depends on lpl_pkg and the lookahead_peak_limiter rtl
module tb_lookahead_peak_limiter;
    timeunit 1ns;
    timeprecision 1ps;
    import lpl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DEPTH = RING_DEPTH;
    localparam int SETTLE_CYCLES = 600;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_beat in_beat = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_stall;
    logic out_valid;
    t_out_beat out_beat;

    lookahead_peak_limiter uut (
        .i_clk(i_clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_beat(in_beat), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_beat(out_beat), .i_out_stall(out_stall),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial forever #4 i_clk = ~i_clk;

    // predictor state
    bit [23:0] ceil_lvl, act_lvl, pole_idle, pole_lim;
    bit [12:0] knee_db;
    bit [23:0] sample_hist [DEPTH];
    bit [23:0] mag_hist [DEPTH];
    int unsigned peak_slots [DEPTH];
    int unsigned dq_head, dq_tail, wr_slot;
    bit [63:0] gain_now;
    bit [63:0] pow_tbl [16];

    t_in_beat pending_beats [$];
    t_out_beat expected_beats [$];
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int limited_beats = 0;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int burst_left = 0;
    int gap_left = 0;
    int mode_left = 0;
    int stall_mode = 0;

    function automatic bit [63:0] root64(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_fix(bit [31:0] x);
        int n;
        bit [63:0] m;
        longint r;
        n = 0;
        while (n < 31 && (x >> (n + 1)) != 0) n++;
        m = 64'(x) << (30 - n);
        r = longint'(n) << 16;
        for (int k = 15; k >= 0; k--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                r = r | (longint'(1) << k);
            end
        end
        return r;
    endfunction

    function automatic bit [63:0] exp2_down(bit [63:0] e);
        bit [63:0] g;
        bit [63:0] ei;
        bit [63:0] f;
        g = 64'd1 << 32;
        ei = e >> 16;
        f = e & 64'hFFFF;
        if (ei >= 32) return 0;
        for (int k = 0; k < 16; k++)
            if (f[15 - k]) g = (g * pow_tbl[k]) >> 32;
        g = g >> ei;
        g = (g + 256) >> 9;
        return (g > UNITY_GAIN) ? 64'(UNITY_GAIN) : g;
    endfunction

    function automatic bit [63:0] ratio_of(bit [23:0] peak);
        bit [63:0] q;
        q = (64'(ceil_lvl) << 23) / peak;
        return (q > UNITY_GAIN) ? 64'(UNITY_GAIN) : q;
    endfunction

    function automatic bit [63:0] target_gain(bit [23:0] peak);
        longint d, rel, half, x, r, mag;
        bit [63:0] kq, red, att;
        if (peak < act_lvl) return UNITY_GAIN;
        if (peak == 0 || ceil_lvl == 0) return UNITY_GAIN;
        if (knee_db == 0) return (peak > ceil_lvl) ? ratio_of(peak) : 64'(UNITY_GAIN);
        d = log2_fix(peak) - log2_fix(ceil_lvl);
        mag = (d < 0) ? -d : d;
        r = (mag * 394566 + 32768) >>> 16;
        rel = (d < 0) ? -r : r;
        half = longint'(knee_db) << 7;
        if (rel <= -half) return UNITY_GAIN;
        if (rel >= half) return ratio_of(peak);
        x = rel + half;
        kq = 64'(knee_db) << 8;
        red = (64'(x) * 64'(x) + kq) / (kq << 1);
        att = (red * 10885 + 32768) >> 16;
        return exp2_down(att);
    endfunction

    function automatic t_out_beat limiter_predict(t_in_beat b);
        int unsigned pos, cnt, back, slot;
        bit [23:0] outgoing, peak;
        bit [63:0] req, delta, coef;
        longint s, p, q;
        t_out_beat o;
        pos = wr_slot;
        cnt = (dq_tail + 2 * DEPTH - dq_head) % (2 * DEPTH);
        if (cnt > 0 && peak_slots[dq_head % DEPTH] == pos) begin
            dq_head = (dq_head + 1) % (2 * DEPTH);
            cnt--;
        end
        while (cnt > 0) begin
            back = (dq_tail + 2 * DEPTH - 1) % (2 * DEPTH);
            slot = peak_slots[back % DEPTH] % DEPTH;
            if (mag_hist[slot] > b.peak_magnitude) break;
            dq_tail = back;
            cnt--;
        end
        peak_slots[dq_tail % DEPTH] = pos;
        dq_tail = (dq_tail + 1) % (2 * DEPTH);
        outgoing = sample_hist[(pos + 1) % DEPTH];
        sample_hist[pos] = b.sample_in;
        mag_hist[pos] = b.peak_magnitude;
        wr_slot = (pos + 1) % DEPTH;
        peak = mag_hist[peak_slots[dq_head % DEPTH] % DEPTH];
        req = target_gain(peak);
        if (req < UNITY_GAIN) limited_beats++;
        if (gain_now > UNITY_GAIN) gain_now = UNITY_GAIN;
        if (req <= gain_now) begin
            gain_now = req;
        end else begin
            delta = req - gain_now;
            coef = (req < UNITY_GAIN) ? 64'(pole_lim) : 64'(pole_idle);
            gain_now = gain_now + ((delta * ((64'd1 << 24) - coef) + (64'd1 << 23)) >> 24);
            if (gain_now > req) gain_now = req;
        end
        s = longint'(signed'(outgoing));
        p = s * longint'(gain_now);
        q = longint'(64'(p + (longint'(1) << 22) + (longint'(1) << 50)) >> 23)
            - (longint'(1) << 27);
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        o.sample_out = q[23:0];
        o.frame_last_out = b.frame_last;
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // driver: bursts of beats separated by random gaps, some of zero length
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_beats.push_back(limiter_predict(in_beat));
                beats_in++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_req != hold_served) begin
            hold_served <= hold_req;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(50, 400);
                stall_mode = $urandom_range(0, 2);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            beats_out++;
            if (expected_beats.size() == 0) begin
                report_mismatch("output beat with nothing expected");
            end else begin
                want = expected_beats.pop_front();
                if (out_beat.sample_out !== want.sample_out)
                    report_mismatch($sformatf("beat %0d sample_out %0d, expected %0d",
                        beats_out, out_beat.sample_out, want.sample_out));
                if (out_beat.frame_last_out !== want.frame_last_out)
                    report_mismatch($sformatf("beat %0d frame_last_out %0b, expected %0b",
                        beats_out, out_beat.frame_last_out, want.frame_last_out));
            end
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CEILING: ceil_lvl = val;
            CFG_KNEE: knee_db = val[12:0];
            CFG_ACT: act_lvl = val;
            CFG_REL_IDLE: pole_idle = val;
            CFG_REL_LIM: pole_lim = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(bit [23:0] c, bit [12:0] k, bit [23:0] a, bit [23:0] pi,
                           bit [23:0] pl);
        write_reg(CFG_CEILING, c);
        write_reg(CFG_KNEE, 24'(k));
        write_reg(CFG_ACT, a);
        write_reg(CFG_REL_IDLE, pi);
        write_reg(CFG_REL_LIM, pl);
    endtask

    task automatic add_beat(bit [23:0] s, bit [23:0] m, bit f);
        t_in_beat b;
        b.sample_in = s;
        b.peak_magnitude = m;
        b.frame_last = f;
        pending_beats.push_back(b);
    endtask

    // random mix per beat: quiet beats, peaks around the ceiling, full-range values, alternating extremes
    task automatic add_random(int n);
        int mode;
        bit [23:0] m;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) m = 24'($urandom_range(0, 24'h0FFFFF));
            else if (mode < 7)
                m = 24'($urandom_range(32'(ceil_lvl) / 2,
                        (32'(ceil_lvl) * 2 < 32'hFFFFFF) ? 32'(ceil_lvl) * 2 : 32'hFFFFFF));
            else if (mode < 9) m = 24'($urandom);
            else m = (i % 2) ? 24'hFFFFFF : 24'h0;
            add_beat(24'($urandom), m, $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        pow_tbl[0] = root64(64'd1 << 63);
        for (int k = 1; k < 16; k++) pow_tbl[k] = root64(pow_tbl[k - 1] << 32);
        ceil_lvl = 24'd4194304;
        knee_db = 0;
        act_lvl = 0;
        pole_idle = 0;
        pole_lim = 0;
        for (int i = 0; i < DEPTH; i++) begin
            sample_hist[i] = 0;
            mag_hist[i] = 0;
            peak_slots[i] = 0;
        end
        dq_head = 0;
        dq_tail = 0;
        wr_slot = 0;
        gain_now = UNITY_GAIN;

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset settings: extremes, zero peak, peak equal to ceiling, above it
        add_beat(24'h7FFFFF, 24'h000000, 1'b0);
        add_beat(24'h800000, 24'hFFFFFF, 1'b1);
        add_beat(24'h000000, 24'h400000, 1'b0);
        add_beat(24'hFFFFFF, 24'h400001, 1'b1);
        for (int i = 0; i < 70; i++)
            add_beat((i % 2) ? 24'h7FFFFF : 24'h800000, (i < 3) ? 24'h7FFFFF : 24'h0, i[0]);
        wait_drained();

        // soft knee with slow release poles, plus a write to an unused index
        set_all(24'd4194304, 13'd1536, 24'd0, 24'hF00000, 24'hFFF000);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        add_beat(24'h400000, 24'h380000, 1'b0);
        add_beat(24'h400000, 24'h480000, 1'b0);
        add_beat(24'h400000, 24'hC00000, 1'b1);
        add_random(200);
        wait_drained();

        hold_req++;
        set_all(24'd4194304, 13'd0, 24'd2000000, 24'd0, 24'd0);
        add_random(300);
        wait_drained();

        set_all(24'd0, 13'd768, 24'd0, 24'h800000, 24'h800000);
        add_random(100);
        wait_drained();

        set_all(24'hFFFFFF, 13'd6144, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_random(150);
        wait_drained();

        set_all(24'd1, 13'd8191, 24'd0, 24'hFFFFFF, 24'd0);
        add_random(150);
        wait_drained();

        set_all(24'd2097152, 13'd6144, 24'd0, 24'hFFFFF0, 24'hFFFFFF);
        add_random(300);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            set_all(24'($urandom_range(24'h100000, 24'hFFFFFF)), 13'($urandom_range(0, 8191)),
                    24'($urandom_range(0, 24'h200000)), 24'($urandom), 24'($urandom));
            add_random(200);
            wait_drained();
        end

        $display("covered %0d beats over eleven register settings, %0d of them under limiting",
                 beats_in, limited_beats);
        $display("hard and soft knee, zero ceiling, activation gate and long output hold exercised");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout with %0d beats still expected", expected_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/lpl_pkg.sv
src/lookahead_peak_limiter.sv
tb/tb_lookahead_peak_limiter.sv
